// ----- sv/key_hash_server_select_defines.svh -----
// Assertion macros used by the key hash server select checker.
`ifndef KEY_HASH_SERVER_SELECT_DEFINES_SVH
`define KEY_HASH_SERVER_SELECT_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define KHSS_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define KHSS_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/khss_pkg.sv -----
// Shared types, constants and command structs of the key hash server select block.
package khss_pkg;

   // Field and datapath widths
   localparam int BYTE_W   = 8;
   localparam int SUM_W    = 16;
   localparam int HASH_W   = 32;
   localparam int CNT_W    = $clog2(HASH_W);
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // Upper half of every hash
   localparam logic [SUM_W-1:0] HASH_HIGH = 16'hFFFF;

   // Register map
   localparam logic [CSR_ADDR_W-1:0] REG_SERVER_COUNT = 2'd0;

   // Input word
   typedef struct packed {
      logic [BYTE_W-1:0] key_byte;
      logic              last_byte;
   } req_type;

   // Result word
   typedef struct packed {
      logic [SUM_W-1:0] server_index;
      logic             no_server;
   } rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic take_byte;
      logic step_div;
      logic load_out;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic div_last;
   } dp_status_type;

endpackage

// ----- sv/khss_ctrl.sv -----
// Controller state machine: input handshake, divide sequencing and result register valid.
module khss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  khss_pkg::dp_status_type dp_status,
   output khss_pkg::dp_cmd_type    dp_cmd
);
   import khss_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = dp_status.count_zero ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (dp_status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      dp_cmd = '0;
      unique case (state_ff)
         ST_IDLE: dp_cmd.take_byte = accept;
         ST_DIV:  dp_cmd.step_div  = 1'b1;
         ST_DONE: dp_cmd.load_out  = out_free;
         default: dp_cmd = '0;
      endcase
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/khss_dp.sv -----
// Datapath: ones' complement byte-pair sum, bit-serial remainder unit and result register.
module khss_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  khss_pkg::dp_cmd_type          dp_cmd,
   input  logic [khss_pkg::BYTE_W-1:0]   key_byte,
   input  logic                          last_byte,
   input  logic [khss_pkg::SUM_W-1:0]    server_count,
   output khss_pkg::dp_status_type       dp_status,
   output khss_pkg::rsp_type             rsp_data
);
   import khss_pkg::*;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(HASH_W - 1);

   // Checksum state
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic              odd_ff, odd_in;

   // Remainder unit
   logic [HASH_W-1:0] dividend_ff, dividend_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  divisor_ff, divisor_in;
   logic              no_srv_ff, no_srv_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Result register
   rsp_type           rsp_ff, rsp_in;

   logic [SUM_W-1:0]  word;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_fold;
   logic [SUM_W:0]    rem_shift;
   logic [SUM_W:0]    rem_diff;
   logic              rem_ge;

   // Form the word: pair with the held low byte, or a lone trailing byte
   assign word     = odd_ff ? {key_byte, held_ff} : {{(SUM_W-BYTE_W){1'b0}}, key_byte};
   assign sum_wide = {1'b0, sum_ff} + {1'b0, word};
   assign sum_fold = sum_wide[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, sum_wide[SUM_W]};

   // One restoring divide step
   assign rem_shift = {rem_ff, dividend_ff[HASH_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   assign dp_status.count_zero = (server_count == '0);
   assign dp_status.div_last   = (cnt_ff == DIV_LAST);

   // Checksum accumulation
   always_comb begin
      sum_in  = sum_ff;
      held_in = held_ff;
      odd_in  = odd_ff;
      if (dp_cmd.take_byte) begin
         if (last_byte) begin
            sum_in  = '0;
            held_in = '0;
            odd_in  = 1'b0;
         end else if (odd_ff) begin
            sum_in  = sum_fold;
            held_in = '0;
            odd_in  = 1'b0;
         end else begin
            held_in = key_byte;
            odd_in  = 1'b1;
         end
      end
   end

   // Start the remainder on key end, then step one bit a cycle
   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      no_srv_in   = no_srv_ff;
      cnt_in      = cnt_ff;
      if (dp_cmd.take_byte && last_byte) begin
         dividend_in = {HASH_HIGH, ~sum_fold};
         rem_in      = '0;
         divisor_in  = server_count;
         no_srv_in   = (server_count == '0);
         cnt_in      = '0;
      end else if (dp_cmd.step_div) begin
         dividend_in = {dividend_ff[HASH_W-2:0], 1'b0};
         rem_in      = rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
         cnt_in      = cnt_ff + 1'b1;
      end
   end

   // Load the result register
   always_comb begin
      rsp_in = rsp_ff;
      if (dp_cmd.load_out) begin
         rsp_in.server_index = rem_ff;
         rsp_in.no_server    = no_srv_ff;
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         held_ff <= '0;
         odd_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         sum_ff  <= sum_in;
         held_ff <= held_in;
         odd_ff  <= odd_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      no_srv_ff   <= no_srv_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ----- sv/key_hash_server_select.sv -----
// Top level of the key hash server select block: register port, controller and datapath.
//
// Key bytes enter on the req channel (req_valid/req_ready, req_data.key_byte and
// req_data.last_byte). Bytes pair into little-endian 16-bit words summed in ones'
// complement; the hash is 0xFFFF0000 | ~sum. Each key yields one word on the rsp
// channel: server_index = hash mod server_count, or no_server = 1 when the count is 0.
// Bytes that are not last are taken one per cycle.
// After the last byte the remainder unit shifts out one dividend bit a cycle, then the
// result register is loaded once it is free; when server_count is zero the divide is
// skipped and the result register is loaded directly. req_ready stays low from the last
// byte until the result register is loaded.
// The result register lets the next key's bytes flow while a result waits; if the
// receiver stalls, the following key's result waits, with req_ready low, until the
// register is free.
// server_count sits at byte address 0 of the APB port; write it only while idle.
// Reset is synchronous: it clears the sum, the controller, the result valid and
// server_count, so no server is available until the register is written.
module key_hash_server_select (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  khss_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output khss_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [khss_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [khss_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [khss_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import khss_pkg::*;

   logic [SUM_W-1:0] server_count_ff, server_count_in;
   logic             csr_wr;
   dp_cmd_type       dp_cmd;
   dp_status_type    dp_status;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready & (paddr == REG_SERVER_COUNT);

   // Register write
   always_comb begin
      server_count_in = server_count_ff;
      if (csr_wr) begin
         server_count_in = pwdata[SUM_W-1:0];
      end
   end

   // Register read
   always_comb begin
      prdata = '0;
      if (paddr == REG_SERVER_COUNT) begin
         prdata = {{(CSR_DATA_W-SUM_W){1'b0}}, server_count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= '0;
      end else begin
         server_count_ff <= server_count_in;
      end
   end

   khss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last_byte),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   khss_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .key_byte     (req_data.key_byte),
      .last_byte    (req_data.last_byte),
      .server_count (server_count_ff),
      .dp_status    (dp_status),
      .rsp_data     (rsp_data)
   );

endmodule

// ----- sv/khss_checker.sv -----
// Port-level checker of the key hash server select block and its bind.
`include "key_hash_server_select_defines.svh"

module khss_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input khss_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input khss_pkg::rsp_type rsp_data,
   input logic              pready
);
   import khss_pkg::*;

   // Result valid is low right after reset
   `KHSS_CHECK_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_valid, "rsp_valid high after reset")

   // A stalled result holds
   `KHSS_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // No server always reads as index zero
   `KHSS_CHECK(a_no_server_index, rsp_valid && rsp_data.no_server |-> rsp_data.server_index == '0, "index set with no server")

   // A key end blocks the next byte while the hash is reduced
   `KHSS_CHECK(a_key_end_stall, req_valid && req_ready && req_data.last_byte |=> !req_ready && pready, "byte taken right after key end")

endmodule

bind key_hash_server_select khss_checker u_khss_checker (.*);
